>>> rtl/assert_macros.svh
// Assertion macros shared by the agent RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SLA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sla_pkg.sv
// Types, codes and helpers for the SARSA(lambda) agent.
`default_nettype none
package sla_pkg;
	typedef enum logic [1:0] {
		OP_FIRST = 2'd0,
		OP_NEXT  = 2'd1,
		OP_LAST  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                opcode;
		logic [7:0]         state_index;
		logic signed [31:0] reward;
		logic [15:0]        rand_explore;
		logic [15:0]        rand_action;
		logic [15:0]        rand_tie;
	} in_item_t;

	typedef struct packed {
		logic [2:0] action;
		logic       action_valid;
	} out_item_t;

	localparam logic [2:0] CFG_NUM_ACTIONS  = 3'd0;
	localparam logic [2:0] CFG_DISCOUNT     = 3'd1;
	localparam logic [2:0] CFG_LEARN_RATE   = 3'd2;
	localparam logic [2:0] CFG_EXPLORE_PROB = 3'd3;
	localparam logic [2:0] CFG_TRACE_DECAY  = 3'd4;
	localparam logic [2:0] CFG_INITIAL_VAL  = 3'd5;

	localparam logic [16:0] ONE_FX = 17'h10000;

	// rates above 1.0 clamp to 1.0
	function automatic logic [16:0] sat_rate(input logic [16:0] r);
		return (r > ONE_FX) ? ONE_FX : r;
	endfunction
endpackage
`default_nettype wire

>>> rtl/sla_mod.sv
// Bit-serial remainder unit: 16-bit dividend modulo a small divisor.
`default_nettype none
`include "assert_macros.svh"
module sla_mod
	import sla_pkg::*;
#(
	parameter int DIV_W = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [15:0]      dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DIV_W-1:0]      rem
);
	logic [15:0]      dvd_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W-1:0] rem_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   stepped;

	// shift in one dividend bit, subtract when it fits
	assign trial   = {rem_q, dvd_q[15]};
	assign stepped = (trial >= {1'b0, dvs_q}) ? (trial - {1'b0, dvs_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 5'd15);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvd_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= stepped[DIV_W-1:0];
				dvd_q <= {dvd_q[14:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

	`SLA_ASSERT_IMP(a_no_restart, clk, arst_n, start, !busy_q)
	`SLA_ASSERT_IMP(a_rem_below, clk, arst_n, done_q, rem_q < dvs_q)
	`SLA_ASSERT_NXT(a_done_ends, clk, arst_n, done_q, !busy_q)
endmodule
`default_nettype wire

>>> rtl/sarsa_lambda_q_table_agent.sv
// Top level of the tabular SARSA(lambda) epsilon-greedy agent.
// One request per step: opcode first, next or last, with the observed state, the reward and
// three random samples; one result per request (chosen action, or action_valid low on a last
// step or unused opcode). Q values and traces live in two single-port synchronous RAMs of
// NUM_STATES x 2^ceil(log2 MAX_ACTIONS) words; a seen bit per state sits in flops and is
// cleared by reset, so no clearing pass is needed. Requests are processed one at a time by a
// sequencer around the shared RAM port. Steps per request, from accept to result ready:
// state index reduction by repeated subtraction when NUM_STATES is below 256; on a first
// step, zeroing the MAX_ACTIONS traces of every seen state; filling all MAX_ACTIONS entries
// of a newly seen state; action choice through the remainder unit when exploring, or a scan
// for the maximum, a tie pick and a second scan when greedy; then a read of the chosen Q. The
// update sweep (next and last steps) visits every state and each pair in use of a seen
// state; a traced pair goes through read, evaluate, multiply, add and write. The RAM port is
// the bottleneck. Config writes are taken any time but must only be issued while the block
// is idle. The result register frees the input side while a result waits to be taken.
`default_nettype none
`include "assert_macros.svh"
module sarsa_lambda_q_table_agent
	import sla_pkg::*;
#(
	parameter int NUM_STATES  = 256,
	parameter int MAX_ACTIONS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int AW    = $clog2(MAX_ACTIONS);
	localparam int NAW   = $clog2(MAX_ACTIONS + 1);
	localparam int SW    = $clog2(NUM_STATES);
	localparam int DEPTH = NUM_STATES << AW;

	typedef enum logic [20:0] {
		ST_IDLE   = 21'h000001,
		ST_MODS   = 21'h000002,
		ST_CLR    = 21'h000004,
		ST_TOUCH  = 21'h000008,
		ST_CHOOSE = 21'h000010,
		ST_WAITA  = 21'h000020,
		ST_SC1_RD = 21'h000040,
		ST_SC1_EV = 21'h000080,
		ST_TIEDIV = 21'h000100,
		ST_WAITT  = 21'h000200,
		ST_SC2_RD = 21'h000400,
		ST_SC2_EV = 21'h000800,
		ST_QA_RD  = 21'h001000,
		ST_QA_EV  = 21'h002000,
		ST_TGT    = 21'h004000,
		ST_SW_RD  = 21'h008000,
		ST_SW_EV  = 21'h010000,
		ST_SW_M   = 21'h020000,
		ST_SW_ADD = 21'h040000,
		ST_SW_WR  = 21'h080000,
		ST_SET    = 21'h100000
	} state_t;

	// config registers
	logic [3:0]         num_actions_q;
	logic [16:0]        discount_q;
	logic [16:0]        learn_rate_q;
	logic [16:0]        explore_q;
	logic [16:0]        decay_q;
	logic signed [31:0] init_q;

	// sequencer
	state_t             st_q;
	in_item_t           in_q;
	logic [7:0]         sidx_q;
	logic [SW:0]        ss_q;
	logic [NAW-1:0]     jj_q;
	logic [AW-1:0]      a_q;
	logic [NAW-1:0]     ties_q;
	logic [NAW-1:0]     cnt_q;
	logic [NAW-1:0]     pick_q;
	logic signed [31:0] max_q;
	logic [NUM_STATES-1:0] seen_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	// datapath
	logic signed [49:0] dprod_q;
	logic signed [32:0] target_q;
	logic [16:0]        coef_q;
	logic [16:0]        trn_q;
	logic [33:0]        diff_q;
	logic signed [31:0] qold_q;
	logic [33:0]        plo_q;
	logic signed [34:0] phi_q;
	logic signed [35:0] delta_q;

	// RAMs
	logic signed [31:0] q_mem [DEPTH];
	logic [16:0]        t_mem [DEPTH];
	logic signed [31:0] q_rd;
	logic [16:0]        t_rd;

	logic [NAW-1:0]     na;
	logic [16:0]        alpha;
	logic [16:0]        lam;
	logic [16:0]        disc;
	logic               explore;
	logic [SW-1:0]      s_w;
	logic [SW-1:0]      ss_w;
	logic               ss_end;
	logic               ss_seen;
	logic [SW-1:0]      row;
	logic [AW-1:0]      col;
	logic [SW+AW-1:0]   addr;
	logic               q_we;
	logic               t_we;
	logic signed [31:0] q_wd;
	logic [16:0]        t_wd;
	logic [NAW-1:0]     jj_nx;
	logic               terminal;
	logic               is_act;
	logic               out_load;
	logic [33:0]        coef_prod;
	logic [33:0]        trn_prod;
	logic [51:0]        full;
	logic signed [36:0] nsum;
	logic signed [31:0] nq;

	logic               mod_start;
	logic [15:0]        mod_dvd;
	logic [NAW-1:0]     mod_dvs;
	logic               mod_busy;
	logic               mod_done;
	logic [NAW-1:0]     mod_rem;

	// action count clamped into 1..MAX_ACTIONS
	always_comb begin
		if (num_actions_q == 4'd0) begin
			na = NAW'(1);
		end else if (32'(num_actions_q) > MAX_ACTIONS) begin
			na = NAW'(MAX_ACTIONS);
		end else begin
			na = NAW'(num_actions_q);
		end
	end

	assign alpha    = sat_rate(learn_rate_q);
	assign lam      = sat_rate(decay_q);
	assign disc     = sat_rate(discount_q);
	assign explore  = {1'b0, in_q.rand_explore} < sat_rate(explore_q);
	assign s_w      = SW'(sidx_q);
	assign ss_w     = ss_q[SW-1:0];
	assign ss_end   = (ss_q == (SW+1)'(NUM_STATES));
	assign ss_seen  = !ss_end && seen_q[ss_w];
	assign jj_nx    = jj_q + NAW'(1);
	assign terminal = (in_q.opcode == OP_LAST);
	assign is_act   = (in_q.opcode == OP_FIRST) || (in_q.opcode == OP_NEXT);

	// result register loads on the final step state or an unused opcode
	assign out_load = (!out_valid_q || out_ready) && ((st_q == ST_SET) ||
		(st_q == ST_MODS && !(32'(sidx_q) >= NUM_STATES) && in_q.opcode == OP_NONE));

	// RAM address: requested state row or sweep row
	always_comb begin
		row = ss_w;
		col = jj_q[AW-1:0];
		case (st_q)
			ST_TOUCH, ST_SC1_RD, ST_SC2_RD: row = s_w;
			ST_QA_RD, ST_SET: begin
				row = s_w;
				col = a_q;
			end
			default: row = ss_w;
		endcase
	end
	assign addr = {row, col};

	// Q update: q + floor(coef * (target - q) / 2^16), saturated
	assign coef_prod = alpha * t_rd;
	assign trn_prod  = t_rd * lam;
	assign full      = {phi_q, 17'b0} + {18'b0, plo_q};
	assign nsum      = {{5{qold_q[31]}}, qold_q} + {delta_q[35], delta_q};
	always_comb begin
		if (nsum[36:31] != {6{nsum[36]}}) begin
			nq = nsum[36] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			nq = nsum[31:0];
		end
	end

	assign q_we = (st_q == ST_TOUCH && !seen_q[s_w]) || (st_q == ST_SW_WR);
	assign t_we = q_we || (st_q == ST_CLR && ss_seen) || (st_q == ST_SET && is_act);
	assign q_wd = (st_q == ST_TOUCH) ? init_q : nq;
	always_comb begin
		case (st_q)
			ST_SET:   t_wd = ONE_FX;
			ST_SW_WR: t_wd = terminal ? 17'd0 : trn_q;
			default:  t_wd = 17'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[addr] <= q_wd;
		end
		q_rd <= q_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			t_mem[addr] <= t_wd;
		end
		t_rd <= t_mem[addr];
	end

	// remainder unit: exploratory action and tie pick
	assign mod_start = (st_q == ST_CHOOSE && explore) || (st_q == ST_TIEDIV);
	assign mod_dvd   = (st_q == ST_CHOOSE) ? in_q.rand_action : in_q.rand_tie;
	assign mod_dvs   = (st_q == ST_CHOOSE) ? na : ties_q;

	sla_mod #(.DIV_W(NAW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dvd),
		.divisor  (mod_dvs),
		.busy     (mod_busy),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_actions_q <= 4'd8;
			discount_q    <= ONE_FX;
			learn_rate_q  <= '0;
			explore_q     <= '0;
			decay_q       <= '0;
			init_q        <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUM_ACTIONS:  num_actions_q <= cfg_data[3:0];
				CFG_DISCOUNT:     discount_q    <= cfg_data[16:0];
				CFG_LEARN_RATE:   learn_rate_q  <= cfg_data[16:0];
				CFG_EXPLORE_PROB: explore_q     <= cfg_data[16:0];
				CFG_TRACE_DECAY:  decay_q       <= cfg_data[16:0];
				CFG_INITIAL_VAL:  init_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			in_q        <= '0;
			sidx_q      <= '0;
			ss_q        <= '0;
			jj_q        <= '0;
			a_q         <= '0;
			ties_q      <= '0;
			cnt_q       <= '0;
			pick_q      <= '0;
			max_q       <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			dprod_q     <= '0;
			target_q    <= '0;
			coef_q      <= '0;
			trn_q       <= '0;
			diff_q      <= '0;
			qold_q      <= '0;
			plo_q       <= '0;
			phi_q       <= '0;
			delta_q     <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						in_q   <= in_data;
						sidx_q <= in_data.state_index;
						st_q   <= ST_MODS;
					end
				end
				// state index modulo NUM_STATES by repeated subtraction
				ST_MODS: begin
					ss_q <= '0;
					jj_q <= '0;
					if (32'(sidx_q) >= NUM_STATES) begin
						sidx_q <= sidx_q - 8'(NUM_STATES);
					end else begin
						case (in_q.opcode)
							OP_FIRST: st_q <= ST_CLR;
							OP_NEXT:  st_q <= ST_TOUCH;
							OP_LAST: begin
								target_q <= {in_q.reward[31], in_q.reward};
								st_q     <= ST_SW_RD;
							end
							// unused opcode: empty result, straight out or via the wait
							default: begin
								if (!out_valid_q || out_ready) begin
									out_data_q <= '0;
									st_q       <= ST_IDLE;
								end else begin
									st_q <= ST_SET;
								end
							end
						endcase
					end
				end
				// first step: zero all traces of seen states
				ST_CLR: begin
					if (ss_end) begin
						jj_q <= '0;
						st_q <= ST_TOUCH;
					end else if (!seen_q[ss_w]) begin
						ss_q <= ss_q + (SW+1)'(1);
					end else if (jj_q == NAW'(MAX_ACTIONS - 1)) begin
						jj_q <= '0;
						ss_q <= ss_q + (SW+1)'(1);
					end else begin
						jj_q <= jj_nx;
					end
				end
				// new state: fill the whole row
				ST_TOUCH: begin
					if (seen_q[s_w]) begin
						jj_q <= '0;
						st_q <= ST_CHOOSE;
					end else if (jj_q == NAW'(MAX_ACTIONS - 1)) begin
						seen_q[s_w] <= 1'b1;
						jj_q        <= '0;
						st_q        <= ST_CHOOSE;
					end else begin
						jj_q <= jj_nx;
					end
				end
				ST_CHOOSE: begin
					jj_q <= '0;
					st_q <= explore ? ST_WAITA : ST_SC1_RD;
				end
				ST_WAITA: begin
					if (mod_done) begin
						a_q  <= AW'(mod_rem);
						st_q <= ST_QA_RD;
					end
				end
				ST_SC1_RD: st_q <= ST_SC1_EV;
				// greedy pass one: maximum and tie count
				ST_SC1_EV: begin
					if (jj_q == '0 || q_rd > max_q) begin
						max_q  <= q_rd;
						ties_q <= NAW'(1);
					end else if (q_rd == max_q) begin
						ties_q <= ties_q + NAW'(1);
					end
					if (jj_nx == na) begin
						st_q <= ST_TIEDIV;
					end else begin
						jj_q <= jj_nx;
						st_q <= ST_SC1_RD;
					end
				end
				ST_TIEDIV: st_q <= ST_WAITT;
				ST_WAITT: begin
					if (mod_done) begin
						pick_q <= mod_rem;
						cnt_q  <= '0;
						jj_q   <= '0;
						st_q   <= ST_SC2_RD;
					end
				end
				ST_SC2_RD: st_q <= ST_SC2_EV;
				// greedy pass two: the picked maximum in index order
				ST_SC2_EV: begin
					if (q_rd == max_q && cnt_q == pick_q) begin
						a_q  <= jj_q[AW-1:0];
						st_q <= ST_QA_RD;
					end else begin
						if (q_rd == max_q) begin
							cnt_q <= cnt_q + NAW'(1);
						end
						jj_q <= jj_nx;
						st_q <= ST_SC2_RD;
					end
				end
				ST_QA_RD: st_q <= ST_QA_EV;
				ST_QA_EV: begin
					dprod_q <= $signed({1'b0, disc}) * q_rd;
					st_q    <= (in_q.opcode == OP_NEXT) ? ST_TGT : ST_SET;
				end
				// target sampled before the sweep
				ST_TGT: begin
					target_q <= {in_q.reward[31], in_q.reward} + dprod_q[48:16];
					ss_q     <= '0;
					jj_q     <= '0;
					st_q     <= ST_SW_RD;
				end
				ST_SW_RD: begin
					if (ss_end) begin
						st_q <= terminal ? ST_SET : ST_SET;
					end else if (!seen_q[ss_w] || jj_q == na) begin
						ss_q <= ss_q + (SW+1)'(1);
						jj_q <= '0;
					end else begin
						st_q <= ST_SW_EV;
					end
				end
				ST_SW_EV: begin
					if (t_rd == 17'd0) begin
						jj_q <= jj_nx;
						st_q <= ST_SW_RD;
					end else begin
						coef_q <= coef_prod[32:16];
						trn_q  <= trn_prod[32:16];
						diff_q <= {target_q[32], target_q} - {{2{q_rd[31]}}, q_rd};
						qold_q <= q_rd;
						st_q   <= ST_SW_M;
					end
				end
				ST_SW_M: begin
					plo_q <= coef_q * diff_q[16:0];
					phi_q <= $signed({1'b0, coef_q}) * $signed(diff_q[33:17]);
					st_q  <= ST_SW_ADD;
				end
				ST_SW_ADD: begin
					delta_q <= full[51:16];
					st_q    <= ST_SW_WR;
				end
				ST_SW_WR: begin
					jj_q <= jj_nx;
					st_q <= ST_SW_RD;
				end
				// chosen pair's trace to 1.0 (write gated by opcode), then result out
				ST_SET: begin
					if (!out_valid_q || out_ready) begin
						out_data_q.action       <= is_act ? 3'(a_q) : 3'd0;
						out_data_q.action_valid <= is_act;
						st_q                    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

	`SLA_ASSERT_NXT(a_accept_starts, clk, arst_n, in_valid && in_ready, st_q == ST_MODS)
	`SLA_ASSERT_IMP(a_q_write_owner, clk, arst_n, q_we,
		(st_q == ST_TOUCH) || (st_q == ST_SW_WR))
	`SLA_ASSERT_IMP(a_action_in_use, clk, arst_n, (st_q == ST_SET) && is_act,
		32'(a_q) < 32'(na))
	`SLA_ASSERT_IMP(a_mod_idle_start, clk, arst_n, mod_start, !mod_busy)
endmodule
`default_nettype wire

>>> bench/sarsa_lambda_q_table_agent_tb.sv
// Self-checking bench for the SARSA(lambda) Q-table agent: directed and random episodes.
`timescale 1ns / 1ps
`default_nettype none
module sarsa_lambda_q_table_agent_tb;
	import sla_pkg::*;

	localparam int STATES = 256;
	localparam int ACTS   = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	sarsa_lambda_q_table_agent u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the learner: Q table, traces, seen bits, registers
	// ------------------------------------------------------------------
	logic signed [31:0] q_tab [STATES*ACTS];
	logic [16:0]        elig  [STATES*ACTS];
	bit                 seen  [STATES];
	logic [3:0]         r_nact;
	logic [16:0]        r_gamma, r_alpha, r_eps, r_lambda;
	logic signed [31:0] r_init;

	out_item_t action_q[$];   // actions still owed by the DUT
	int        errs = 0;
	bit        idle_en;       // random idling on both sides when set

	// rates above 1.0 count as 1.0
	function automatic longint clip_rate(logic [16:0] r);
		return (r > 17'h10000) ? 64'd65536 : longint'(r);
	endfunction

	function automatic int unsigned acts_live();
		if (r_nact == 0)
			return 1;
		if (r_nact > ACTS)
			return ACTS;
		return r_nact;
	endfunction

	task automatic mark_seen(int s);
		if (!seen[s]) begin
			seen[s] = 1;
			for (int j = 0; j < ACTS; j++) begin
				q_tab[s*ACTS+j] = r_init;
				elig[s*ACTS+j]  = '0;
			end
		end
	endtask

	// epsilon-greedy pick; ties among maxima resolved by rand_tie
	function automatic int pick_action(int s, int unsigned na, in_item_t it);
		int best;
		int ties;
		int sel;
		if (longint'(it.rand_explore) < clip_rate(r_eps))
			return it.rand_action % na;
		best = 0;
		ties = 0;
		for (int j = 1; j < na; j++)
			if (q_tab[s*ACTS+j] > q_tab[s*ACTS+best])
				best = j;
		for (int j = 0; j < na; j++)
			if (q_tab[s*ACTS+j] == q_tab[s*ACTS+best])
				ties++;
		sel = it.rand_tie % ties;
		for (int j = 0; j < na; j++)
			if (q_tab[s*ACTS+j] == q_tab[s*ACTS+best]) begin
				if (sel == 0)
					return j;
				sel--;
			end
		return best;
	endfunction

	// move every traced pair toward target, then decay or clear its trace
	task automatic trace_update(longint target, bit terminal, int unsigned na);
		longint alpha, lam, coef, qv, nq;
		alpha = clip_rate(r_alpha);
		lam   = clip_rate(r_lambda);
		for (int s = 0; s < STATES; s++) begin
			if (!seen[s])
				continue;
			for (int j = 0; j < na; j++) begin
				int k;
				k = s*ACTS + j;
				if (elig[k] == 0)
					continue;
				coef = (alpha * longint'(elig[k])) >> 16;
				qv   = q_tab[k];
				nq   = qv + ((coef * (target - qv)) >>> 16);
				if (nq > 64'sd2147483647)
					nq = 64'sd2147483647;
				if (nq < -64'sd2147483648)
					nq = -64'sd2147483648;
				q_tab[k] = nq[31:0];
				elig[k]  = terminal ? 17'd0 : 17'((longint'(elig[k]) * lam) >> 16);
			end
		end
	endtask

	task automatic predict_step(in_item_t it);
		out_item_t    res;
		int           s;
		int           a;
		int unsigned  na;
		longint       rw;
		longint       target;
		longint       qa;
		s   = it.state_index;
		na  = acts_live();
		rw  = it.reward;
		res = '0;
		case (it.opcode)
			OP_FIRST: begin
				foreach (elig[k])
					elig[k] = '0;
				mark_seen(s);
				a = pick_action(s, na, it);
				elig[s*ACTS+a] = 17'h10000;
				res.action = a[2:0];
				res.action_valid = 1'b1;
			end
			OP_NEXT: begin
				mark_seen(s);
				a = pick_action(s, na, it);
				qa = q_tab[s*ACTS+a];
				// target sampled before the sweep touches Q
				target = rw + ((clip_rate(r_gamma) * qa) >>> 16);
				trace_update(target, 1'b0, na);
				elig[s*ACTS+a] = 17'h10000;
				res.action = a[2:0];
				res.action_valid = 1'b1;
			end
			OP_LAST: trace_update(rw, 1'b1, na);
			default: ;
		endcase
		action_q.push_back(res);
	endtask

	// ------------------------------------------------------------------
	// Clock, reset, limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("Verification failed");
		$finish;
	end

	// result side: random stalls unless idling is switched off
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= idle_en ? ($urandom_range(99) >= 35) : 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (action_q.size() == 0) begin
				$display("%0t: unexpected result action=%0d valid=%0b", $time,
					out_data.action, out_data.action_valid);
				errs++;
			end else begin
				out_item_t want;
				want = action_q.pop_front();
				if (out_data.action !== want.action) begin
					$display("%0t: action expected %0d actual %0d", $time,
						want.action, out_data.action);
					errs++;
				end
				if (out_data.action_valid !== want.action_valid) begin
					$display("%0t: action_valid expected %0b actual %0b", $time,
						want.action_valid, out_data.action_valid);
					errs++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Leaves in_valid high after the handshake so back-to-back requests never
	// see a low/high pair in one step; park_input drops it.
	task automatic send_step(in_item_t it);
		if (idle_en && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 35);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		predict_step(it);
	endtask

	task automatic park_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every owed result came back, plus a short settle
	task automatic drain();
		park_input();
		while (action_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_NUM_ACTIONS:  r_nact   = val[3:0];
			CFG_DISCOUNT:     r_gamma  = val[16:0];
			CFG_LEARN_RATE:   r_alpha  = val[16:0];
			CFG_EXPLORE_PROB: r_eps    = val[16:0];
			CFG_TRACE_DECAY:  r_lambda = val[16:0];
			CFG_INITIAL_VAL:  r_init   = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_all(logic [3:0] na, logic [16:0] g, logic [16:0] al,
			logic [16:0] ep, logic [16:0] la, logic [31:0] iv);
		cfg_write(CFG_NUM_ACTIONS, {28'd0, na});
		cfg_write(CFG_DISCOUNT, {15'd0, g});
		cfg_write(CFG_LEARN_RATE, {15'd0, al});
		cfg_write(CFG_EXPLORE_PROB, {15'd0, ep});
		cfg_write(CFG_TRACE_DECAY, {15'd0, la});
		cfg_write(CFG_INITIAL_VAL, iv);
	endtask

	// mostly a handful of states so the sweeps stay short; now and then any state
	function automatic in_item_t rand_step(op_t op);
		in_item_t it;
		it.opcode       = op;
		it.state_index  = ($urandom_range(99) < 3) ? 8'($urandom_range(255))
		                                           : 8'($urandom_range(11));
		case ($urandom_range(3))
			0: it.reward = $urandom;
			1: it.reward = 32'sd0;
			default: it.reward = $signed($urandom_range(8 << 16)) - (4 << 16);
		endcase
		it.rand_explore = 16'($urandom);
		it.rand_action  = 16'($urandom);
		it.rand_tie     = 16'($urandom);
		return it;
	endfunction

	function automatic in_item_t mk(op_t op, logic [7:0] s, logic [31:0] rw,
			logic [15:0] re, logic [15:0] ra, logic [15:0] rt);
		in_item_t it;
		it.opcode = op;
		it.state_index = s;
		it.reward = rw;
		it.rand_explore = re;
		it.rand_action = ra;
		it.rand_tie = rt;
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset values: all-tied Q rows, greedy with rand_tie, every opcode incl. unused.
	task automatic test_reset_defaults();
		send_step(mk(OP_FIRST, 8'd0,   32'h0,        16'h0000, 16'h0000, 16'h0000));
		send_step(mk(OP_NEXT,  8'd255, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_step(mk(OP_NEXT,  8'd0,   32'h80000000, 16'h1234, 16'h0007, 16'h0005));
		send_step(mk(OP_NONE,  8'd3,   32'h00010000, 16'h0000, 16'h0000, 16'h0000));
		send_step(mk(OP_LAST,  8'd9,   32'hFFFF0000, 16'h0000, 16'h0000, 16'h0000));
		drain();
	endtask

	// Learning with extreme register values: rates above one, bad action
	// counts, initial values at the rails, saturating rewards.
	task automatic test_config_extremes();
		cfg_all(4'd15, 17'h1FFFF, 17'h1FFFF, 17'd0, 17'h1FFFF, 32'h7FFFFFFF);
		send_step(mk(OP_FIRST, 8'd20, 32'h0,        16'h0000, 16'h0000, 16'h0003));
		send_step(mk(OP_NEXT,  8'd21, 32'h7FFFFFFF, 16'hFFFF, 16'h0000, 16'h0001));
		send_step(mk(OP_NEXT,  8'd20, 32'h7FFFFFFF, 16'h0000, 16'h0000, 16'hFFFF));
		send_step(mk(OP_LAST,  8'd0,  32'h80000000, 16'h0000, 16'h0000, 16'h0000));
		drain();
		cfg_all(4'd0, 17'd0, 17'h10000, 17'h10000, 17'h10000, 32'h80000000);
		send_step(mk(OP_FIRST, 8'd22, 32'h0,        16'hFFFF, 16'hFFFF, 16'h0000));
		send_step(mk(OP_NEXT,  8'd22, 32'h80000000, 16'h0000, 16'h0005, 16'h0000));
		send_step(mk(OP_NEXT,  8'd23, 32'h7FFFFFFF, 16'hFFFF, 16'h0002, 16'h0000));
		send_step(mk(OP_LAST,  8'd1,  32'h80000000, 16'h0000, 16'h0000, 16'h0000));
		drain();
		// shrink the action count after rows were built at full width
		cfg_all(4'd1, 17'h08000, 17'h04000, 17'd0, 17'h0C000, 32'h00010000);
		send_step(mk(OP_FIRST, 8'd20, 32'h0,        16'h0000, 16'hFFFF, 16'hFFFF));
		send_step(mk(OP_NEXT,  8'd24, 32'h00030000, 16'h0000, 16'h0000, 16'h0000));
		send_step(mk(OP_NEXT,  8'd20, 32'hFFFD0000, 16'h0000, 16'h0000, 16'h0000));
		send_step(mk(OP_LAST,  8'd0,  32'h00050000, 16'h0000, 16'h0000, 16'h0000));
		drain();
	endtask

	// Well-formed episodes with random content under a series of settings,
	// with some noise (unused opcode, stray first/last) mixed in.
	task automatic test_random_episodes();
		int sent;
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: cfg_all(4'd4, 17'hE000, 17'h8000, 17'h2000, 17'hC000, 32'h0);
				1: cfg_all(4'd8, 17'h10000, 17'h10000, 17'd0, 17'h10000, 32'hFFFE0000);
				2: cfg_all(4'd2, 17'd0, 17'h0100, 17'h8000, 17'd0, 32'h00020000);
				3: cfg_all(4'($urandom_range(15)), 17'($urandom_range(17'h1FFFF)),
					17'($urandom_range(17'h1FFFF)), 17'($urandom_range(17'h10000)),
					17'($urandom_range(17'h1FFFF)), $urandom);
				4: cfg_all(4'd3, 17'hFFFF, 17'hFFFF, 17'h0001, 17'hFFFF, 32'h00008000);
				default: cfg_all(4'd8, 17'hF000, 17'h6000, 17'h1000, 17'h8000, $urandom);
			endcase
			// one phase with no idling at all
			idle_en = (ph != 2);
			for (int n = 0; n < 44; ) begin
				int len;
				if ($urandom_range(99) < 12) begin
					send_step(rand_step(op_t'($urandom_range(3))));
					n++;
					continue;
				end
				len = $urandom_range(6, 1);
				send_step(rand_step(OP_FIRST));
				for (int k = 0; k < len; k++)
					send_step(rand_step(OP_NEXT));
				if ($urandom_range(9) != 0)
					send_step(rand_step(OP_LAST));
				n += len + 2;
			end
			drain();
			sent++;
		end
		idle_en = 1'b1;
	endtask

	// sender holds off mid-episode until the pipeline is empty, then resumes
	task automatic test_sender_pause();
		send_step(rand_step(OP_FIRST));
		send_step(rand_step(OP_NEXT));
		park_input();
		while (action_q.size() != 0)
			@(posedge clk);
		send_step(rand_step(OP_NEXT));
		send_step(rand_step(OP_LAST));
		drain();
	endtask

	initial begin
		idle_en   = 1'b1;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		foreach (seen[s])
			seen[s] = 0;
		foreach (q_tab[k]) begin
			q_tab[k] = '0;
			elig[k]  = '0;
		end
		r_nact   = 4'd8;
		r_gamma  = 17'h10000;
		r_alpha  = '0;
		r_eps    = '0;
		r_lambda = '0;
		r_init   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_config_extremes();
		test_random_episodes();
		test_sender_pause();

		if (errs == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/sla_pkg.sv
rtl/sla_mod.sv
rtl/sarsa_lambda_q_table_agent.sv
bench/sarsa_lambda_q_table_agent_tb.sv
